[design/wcq_pkg.sv]
// ----------------------------------------------------------------------------
// wcq_pkg
// Shared widths, register indexes and mode codes for the coefficient quantizer.
// ----------------------------------------------------------------------------
package wcq_pkg;

  localparam int unsigned COEF_W    = 16;
  localparam int unsigned MAG_W     = 15;
  localparam int unsigned LEVEL_W   = 4;
  localparam int unsigned IN_DATA_W = 24;  // 20 payload bits padded to bytes
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 4;

  typedef logic [COEF_W-1:0]    coef_t;
  typedef logic [LEVEL_W-1:0]   level_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  typedef enum logic {
    QM_UNIFORM  = 1'b0,
    QM_DEADZONE = 1'b1
  } quant_mode_t;

  localparam cfg_idx_t CFG_IDX_TRUNC = 1'b0;
  localparam cfg_idx_t CFG_IDX_MODE  = 1'b1;

endpackage

[design/wcq_core.sv]
// ----------------------------------------------------------------------------
// wcq_core
// Combinational quantization of one sign-magnitude coefficient.
// ----------------------------------------------------------------------------
module wcq_core (
  input  wcq_pkg::coef_t       coef,
  input  wcq_pkg::level_t      gcli,
  input  wcq_pkg::level_t      gtli,
  input  wcq_pkg::quant_mode_t mode,
  output wcq_pkg::coef_t       quantized
);
  import wcq_pkg::*;

  logic [MAG_W-1:0]  mag;
  logic [4:0]        scale;
  logic [4:0]        down;
  logic [31:0]       mag32;
  logic [31:0]       shifted;
  logic [31:0]       sum;
  logic [31:0]       t;
  logic [COEF_W-1:0] q_uni;
  logic [COEF_W-1:0] q_dz;
  logic [COEF_W-1:0] q;
  logic              above;

  assign mag   = coef[MAG_W-1:0];
  assign above = gcli > gtli;
  assign scale = {1'b0, gcli} - {1'b0, gtli} + 5'd1;
  assign down  = {1'b0, gcli} + 5'd1;
  assign mag32 = {17'd0, mag};

  // m * (2^scale - 1) plus the rounding term, then dropped by gcli+1 planes
  assign shifted = mag32 << scale;
  assign sum     = shifted - mag32 + (32'd1 << gcli);
  assign t       = sum >> down;
  assign q_uni   = t[COEF_W-1:0] << gtli;
  assign q_dz    = ({1'b0, mag} >> gtli) << gtli;

  always_comb begin
    unique case (mode)
      QM_DEADZONE: q = q_dz;
      QM_UNIFORM:  q = q_uni;
      default:     q = q_uni;
    endcase
    if (!above) begin
      quantized = '0;
    end else if (q != '0) begin
      quantized = q | {coef[COEF_W-1], {(COEF_W-1){1'b0}}};
    end else begin
      quantized = '0;
    end
  end

endmodule

[design/wavelet_coefficient_quantizer.sv]
// ----------------------------------------------------------------------------
// wavelet_coefficient_quantizer
// Streaming quantizer for sign-magnitude wavelet coefficients.
// pipeline: input register (s1), then result register driving out_tdata
// throughput: one beat per cycle unless out_tready stalls; set by the single-pass datapath
// between the registers; such stalls propagate back through both stages without bubbles
// reset: synchronous active-low rst_n clears valid flags, gtli to 0, mode to uniform
// ----------------------------------------------------------------------------
module wavelet_coefficient_quantizer (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_we,
  input  wcq_pkg::cfg_idx_t                  cfg_index,
  input  logic [wcq_pkg::CFG_DAT_W-1:0]      cfg_wdata,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [wcq_pkg::IN_DATA_W-1:0]      in_tdata,   // coefficient[15:0], group_gcli[19:16]
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [wcq_pkg::COEF_W-1:0]         out_tdata   // quantized[15:0]
);
  import wcq_pkg::*;

  level_t      gtli_r;
  quant_mode_t mode_r;

  logic        s1_valid_r;
  coef_t       s1_coef_r;
  level_t      s1_gcli_r;
  logic        out_valid_r;
  coef_t       out_data_r;
  coef_t       quantized;
  logic        out_adv;
  logic        s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gtli_r <= '0;
      mode_r <= QM_UNIFORM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_TRUNC: gtli_r <= cfg_wdata[LEVEL_W-1:0];
        CFG_IDX_MODE:  mode_r <= quant_mode_t'(cfg_wdata[0]);
        default: ;
      endcase
    end
  end

  assign out_adv   = !out_valid_r || out_tready;
  assign s1_adv    = !s1_valid_r || out_adv;
  assign in_tready = s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_tvalid) begin
      s1_coef_r <= in_tdata[COEF_W-1:0];
      s1_gcli_r <= in_tdata[COEF_W+LEVEL_W-1:COEF_W];
    end
  end

  wcq_core u_core (
    .coef      (s1_coef_r),
    .gcli      (s1_gcli_r),
    .gtli      (gtli_r),
    .mode      (mode_r),
    .quantized (quantized)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_data_r <= quantized;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[sim/wavelet_coefficient_quantizer_tb.sv]
// ----------------------------------------------------------------------------
// wavelet_coefficient_quantizer_tb
// Self-checking bench for the coefficient quantizer. Coefficient beats go in
// under both quantization modes and a range of truncation levels. Directed
// corner cases come first, then random groups under three back-pressure
// profiles. Every result beat is compared in order against a local predictor.
// ----------------------------------------------------------------------------
module wavelet_coefficient_quantizer_tb;
  import wcq_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned SETTLE_TICKS = 6;
  localparam int unsigned GROUP_BEATS  = 60;
  localparam int unsigned GROUPS       = 8;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  cfg_idx_t             cfg_index = CFG_IDX_TRUNC;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;   // coefficient[15:0], group_gcli[19:16]
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [COEF_W-1:0]    out_tdata;       // quantized[15:0]

  level_t      gtli_shadow = '0;
  quant_mode_t mode_shadow = QM_UNIFORM;
  coef_t       pending_quantized[$];
  coef_t       oldest_quantized;
  int          mismatch_count = 0;
  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  wavelet_coefficient_quantizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic coef_t quantize_coef(coef_t coef, level_t gcli, level_t gtli,
                                          quant_mode_t mode);
    logic [31:0] mag;
    logic [31:0] acc;
    logic [15:0] t16;
    int unsigned scale;
    coef_t       q;
    mag = {17'd0, coef[14:0]};
    q = '0;
    if (gcli > gtli) begin
      if (mode == QM_DEADZONE) begin
        acc = (mag >> gtli) << gtli;
        q = acc[15:0];
      end else begin
        // rounding offset depends on the group's top bit plane
        scale = int'(gcli) - int'(gtli) + 1;
        acc = ((mag << scale) - mag + (32'd1 << gcli)) >> (int'(gcli) + 1);
        t16 = acc[15:0];
        q = t16 << gtli;
      end
      if (q != '0) begin
        q = q | {coef[15], 15'd0};
      end
    end
    return q;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_coef(input coef_t coef, input level_t gcli);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0000, gcli, coef};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_quantized.push_back(quantize_coef(coef, gcli, gtli_shadow, mode_shadow));
  endtask

  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    while (pending_quantized.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DAT_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input level_t gtli, input quant_mode_t mode);
    drain_pipeline();
    write_reg(CFG_IDX_TRUNC, gtli);
    write_reg(CFG_IDX_MODE, {{(CFG_DAT_W-1){1'b0}}, mode});
    gtli_shadow = gtli;
    mode_shadow = mode;
  endtask

  task automatic test_uniform_corners();
    apply_settings(4'd0, QM_UNIFORM);
    send_coef(16'h7FFF, 4'd15);
    send_coef(16'hFFFF, 4'd15);
    send_coef(16'h8000, 4'd1);   // negative zero loses its sign
    send_coef(16'h0001, 4'd0);   // group not above truncation
    send_coef(16'h8001, 4'd1);
    apply_settings(4'd14, QM_UNIFORM);
    send_coef(16'hFFFF, 4'd15);
    send_coef(16'h7FFF, 4'd14);
    send_coef(16'h8001, 4'd15);  // rounds to zero, sign dropped
    send_coef(16'hC000, 4'd15);
  endtask

  task automatic test_deadzone_corners();
    apply_settings(4'd4, QM_DEADZONE);
    send_coef(16'h800F, 4'd5);   // low planes only, sign dropped
    send_coef(16'hFFFF, 4'd15);
    send_coef(16'h0010, 4'd4);
    send_coef(16'h9234, 4'd5);
    apply_settings(4'd15, QM_DEADZONE);
    send_coef(16'hFFFF, 4'd15);  // nothing is above the top level
    apply_settings(4'd0, QM_DEADZONE);
    send_coef(16'hABCD, 4'd1);
    send_coef(16'h0000, 4'd0);
    send_coef(16'h8000, 4'd15);
  endtask

  task automatic test_random_stream(input int gap_pct, input int stall_pct);
    level_t      gtli;
    level_t      gcli;
    quant_mode_t mode;
    logic [31:0] mag;
    coef_t       coef;
    int unsigned pick;
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    for (int g = 0; g < GROUPS; g++) begin
      pick = $urandom_range(9);
      if (pick == 0) begin
        gtli = 4'd0;
      end else if (pick == 1) begin
        gtli = 4'd15;
      end else begin
        gtli = level_t'($urandom_range(15));
      end
      mode = quant_mode_t'($urandom_range(1));
      apply_settings(gtli, mode);
      for (int n = 0; n < GROUP_BEATS; n++) begin
        // mostly groups that survive truncation; half the magnitudes are masked to fit gcli
        if (gtli != 4'd15 && $urandom_range(3) != 0) begin
          gcli = level_t'($urandom_range(15, int'(gtli) + 1));
        end else begin
          gcli = level_t'($urandom_range(15));
        end
        if ($urandom_range(1) == 1) begin
          mag = $urandom & ((32'd1 << gcli) - 1) & 32'h7FFF;
          coef = {1'($urandom_range(1)), mag[14:0]};
        end else begin
          coef = coef_t'($urandom);
        end
        send_coef(coef, gcli);
      end
    end
  endtask

  // result checker and receiver back-pressure
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_quantized.size() == 0) begin
        report_mismatch($sformatf("result beat %h with nothing pending", out_tdata));
      end else begin
        oldest_quantized = pending_quantized.pop_front();
        if (out_tdata !== oldest_quantized) begin
          report_mismatch($sformatf("quantized %h, predicted %h", out_tdata,
                                    oldest_quantized));
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("wavelet_coefficient_quantizer_tb: done, errors");
      $finish;
    end
  end

  initial begin
    send_gap_pct = 32;
    recv_stall_pct = 87;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_uniform_corners();
    test_deadzone_corners();
    test_random_stream(32, 87);
    test_random_stream(87, 32);
    test_random_stream(0, 0);
    drain_pipeline();
    if (mismatch_count == 0) begin
      $display("wavelet_coefficient_quantizer_tb: done, clean");
    end else begin
      $display("wavelet_coefficient_quantizer_tb: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
design/wcq_pkg.sv
design/wcq_core.sv
design/wavelet_coefficient_quantizer.sv
sim/wavelet_coefficient_quantizer_tb.sv
